FILE: rtl/strs_pkg.sv
package strs_pkg;

    // Tree geometry: a perfect binary tree, root at node 1, leaves at
    // ELEMENT_COUNT .. 2*ELEMENT_COUNT-1.
    localparam int ELEMENT_COUNT = 256;
    localparam int TREE_LEVELS   = $clog2(ELEMENT_COUNT);
    localparam int NODE_DEPTH    = 2 * ELEMENT_COUNT;
    localparam int NODE_AW       = TREE_LEVELS + 1;

    // Field widths.
    localparam int POS_W   = 8;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 44;

    typedef logic [NODE_AW-1:0] node_addr_t;
    // Query bounds are half-open and may reach NODE_DEPTH.
    typedef logic [NODE_AW:0]   bound_t;
    typedef logic [SUM_W-1:0]   sum_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WLEAF,
        ST_WUP,
        ST_QSTEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t                     kind;
        logic [POS_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          range_start;
        logic [POS_W-1:0]          range_end;
    } item_t;

    typedef struct packed {
        logic valid;
        sum_t sum;
    } result_t;

endpackage

FILE: rtl/strs_ram.sv
module strs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/strs_engine.sv
module strs_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  strs_pkg::item_t   item,
    output logic              ready,
    output strs_pkg::result_t res,
    input  logic              res_ready
);
    import strs_pkg::*;

    state_t     state_reg, state_next;
    kind_t      kind_reg, kind_next;
    node_addr_t node_reg, node_next;
    sum_t       cur_reg, cur_next;
    sum_t       acc_reg, acc_next;
    bound_t     lo_reg, lo_next;
    bound_t     hi_reg, hi_next;
    logic       pend_reg, pend_next;
    node_addr_t clr_cnt_reg, clr_cnt_next;

    logic       wr_en;
    node_addr_t wr_addr;
    sum_t       wr_data;
    logic       rd_en;
    node_addr_t rd_addr;
    sum_t       rd_data;

    node_addr_t parent;
    bound_t     hi_dec;
    sum_t       path_sum;

    assign parent   = node_reg >> 1;
    assign hi_dec   = hi_reg - bound_t'(1);
    assign path_sum = cur_reg + rd_data;

    strs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == node_addr_t'(NODE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    state_next = (item.kind == KIND_WRITE) ? ST_WLEAF : ST_QSTEP;
                end
            end
            ST_WLEAF: state_next = ST_WUP;
            ST_WUP: begin
                if (parent == node_addr_t'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_QSTEP: begin
                if (lo_reg >= hi_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Memory control and handshake outputs.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = node_reg;
        wr_data = cur_reg;
        rd_en   = 1'b0;
        rd_addr = node_reg ^ node_addr_t'(1);
        ready   = 1'b0;
        res     = '{valid: 1'b0, sum: acc_reg};
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            ST_IDLE: ready = 1'b1;
            ST_WLEAF: begin
                // Store the leaf and fetch its sibling.
                wr_en = 1'b1;
                rd_en = 1'b1;
            end
            ST_WUP: begin
                // Parent takes the sum of the two children; fetch the next sibling.
                wr_en   = 1'b1;
                wr_addr = parent;
                wr_data = path_sum;
                rd_en   = (parent != node_addr_t'(1));
                rd_addr = parent ^ node_addr_t'(1);
            end
            ST_QSTEP: begin
                if (lo_reg < hi_reg) begin
                    if (lo_reg[0]) begin
                        rd_en   = 1'b1;
                        rd_addr = lo_reg[NODE_AW-1:0];
                    end else if (hi_reg[0]) begin
                        rd_en   = 1'b1;
                        rd_addr = hi_dec[NODE_AW-1:0];
                    end
                end
            end
            ST_DONE: res.valid = 1'b1;
            default: ;
        endcase
    end

    // Datapath registers.
    always_comb begin
        kind_next    = kind_reg;
        node_next    = node_reg;
        cur_next     = cur_reg;
        acc_next     = acc_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pend_next    = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: clr_cnt_next = clr_cnt_reg + node_addr_t'(1);
            ST_IDLE: begin
                if (start) begin
                    kind_next = item.kind;
                    node_next = node_addr_t'(ELEMENT_COUNT) + node_addr_t'(item.index);
                    cur_next  = {{(SUM_W - VALUE_W){item.value[VALUE_W-1]}}, item.value};
                    acc_next  = '0;
                    lo_next   = bound_t'(ELEMENT_COUNT) + bound_t'(item.range_start);
                    hi_next   = bound_t'(ELEMENT_COUNT) + bound_t'(item.range_end)
                                + bound_t'(1);
                end
            end
            ST_WUP: begin
                cur_next  = path_sum;
                node_next = parent;
            end
            ST_QSTEP: begin
                // Fold in the node read on the previous cycle.
                if (pend_reg) begin
                    acc_next = acc_reg + rd_data;
                end
                if (lo_reg < hi_reg) begin
                    if (lo_reg[0]) begin
                        lo_next   = lo_reg + bound_t'(1);
                        pend_next = 1'b1;
                    end else if (hi_reg[0]) begin
                        hi_next   = hi_dec;
                        pend_next = 1'b1;
                    end else begin
                        lo_next = lo_reg >> 1;
                        hi_next = hi_reg >> 1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        node_reg <= node_next;
        cur_reg  <= cur_next;
        acc_reg  <= acc_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
    end

    // A write never reads the node it is writing in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("node memory read and write collide");

    // The upward walk stops before it would pass the root.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WUP) |-> (node_reg != node_addr_t'(1)))
        else $error("write walk passed the root");

    // A write item always reports a zero sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && kind_reg == KIND_WRITE) |-> (acc_reg == '0))
        else $error("write item reports a non-zero sum");

    // A query only finishes once no node read is still outstanding.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QSTEP && state_next == ST_DONE) |=> !pend_reg)
        else $error("query finished with a read outstanding");

endmodule

FILE: rtl/segment_tree_range_sum_unit.sv
// Channel   Direction  Signals                              Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser    one write or range query
// m_        out        m_tvalid m_tready m_tdata            one range sum per item
//
// After reset the node memory is cleared, one node a cycle, with s_tready low.
// A write does a leaf store, then one node a cycle up the eight levels.
// A query reads at most two nodes per level through the single read port of the node
// memory, then shifts both bounds up to the next level.
// A stalled m_ side holds the engine in its final state until the output register is free.
module segment_tree_range_sum_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // index[7:0], value[39:8], range_start[47:40], range_end[55:48]
    input  logic [55:0] s_tdata,
    // kind[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // range_sum[43:0], zero fill [47:44]
    output logic [47:0] m_tdata
);
    import strs_pkg::*;

    item_t   item;
    result_t res;
    logic    eng_ready;
    logic    out_free;
    logic    m_tvalid_reg, m_tvalid_next;
    sum_t    m_sum_reg, m_sum_next;

    // Unpack the input transfer.
    assign item.kind        = kind_t'(s_tuser[0]);
    assign item.index       = s_tdata[7:0];
    assign item.value       = s_tdata[39:8];
    assign item.range_start = s_tdata[47:40];
    assign item.range_end   = s_tdata[55:48];

    assign s_tready = eng_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    strs_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && eng_ready),
        .item      (item),
        .ready     (eng_ready),
        .res       (res),
        .res_ready (out_free)
    );

    // Output register: loaded when the engine finishes and the slot is free.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_sum_next    = m_sum_reg;
        if (res.valid && out_free) begin
            m_tvalid_next = 1'b1;
            m_sum_next    = res.sum;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sum_reg <= m_sum_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(48 - SUM_W){1'b0}}, m_sum_reg};

endmodule

FILE: test/tb_segment_tree_range_sum_unit.sv
module tb_segment_tree_range_sum_unit;
    import strs_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // index[7:0], value[39:8], range_start[47:40], range_end[55:48]
    logic [55:0] s_tdata = '0;
    // kind[0]
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // range_sum[43:0], zero fill [47:44]
    logic [47:0] m_tdata;

    // Operations waiting to be sent, and the sums that the block owes us.
    item_t       queued_ops[$];
    sum_t        owed_sums[$];

    // Our own copy of the array contents, kept sign-extended to the sum width.
    sum_t        element_vals[ELEMENT_COUNT];

    int          fail_count = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          ready_mode = 3;
    int          ready_cycles = 0;

    segment_tree_range_sum_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a period of 10 time units.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one operation to the local array and returns the sum it produces.
    function automatic sum_t apply_op(item_t op);
        sum_t acc;
        int   first;
        int   last;
        acc = '0;
        if (op.kind == KIND_WRITE) begin
            if (int'(op.index) < ELEMENT_COUNT) begin
                element_vals[op.index] = {{(SUM_W-VALUE_W){op.value[VALUE_W-1]}}, op.value};
            end
        end else begin
            first = int'(op.range_start);
            last  = int'(op.range_end);
            // Positions past the array count as absent.
            if (last > ELEMENT_COUNT - 1) begin
                last = ELEMENT_COUNT - 1;
            end
            for (int p = first; p <= last; p++) begin
                acc += element_vals[p];
            end
        end
        return acc;
    endfunction

    // Element values lean towards the extremes of the 32-bit range.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Fields that an operation ignores still carry random bits.
    task automatic add_write(input logic [POS_W-1:0] idx, input logic [VALUE_W-1:0] val);
        item_t op;
        op.kind        = KIND_WRITE;
        op.index       = idx;
        op.value       = val;
        op.range_start = $urandom;
        op.range_end   = $urandom;
        queued_ops.push_back(op);
    endtask

    task automatic add_query(input logic [POS_W-1:0] first, input logic [POS_W-1:0] last);
        item_t op;
        op.kind        = KIND_QUERY;
        op.index       = $urandom;
        op.value       = $urandom;
        op.range_start = first;
        op.range_end   = last;
        queued_ops.push_back(op);
    endtask

    // A random query: whole array, single element, short window, inverted or arbitrary.
    task automatic add_random_query();
        int first;
        int last;
        case ($urandom_range(0, 5))
            0: begin
                first = 0;
                last  = ELEMENT_COUNT - 1;
            end
            1: begin
                first = $urandom_range(0, 255);
                last  = first;
            end
            2: begin
                first = $urandom_range(0, 255);
                last  = first + $urandom_range(0, 15);
                if (last > 255) begin
                    last = 255;
                end
            end
            3: begin
                first = $urandom_range(1, 255);
                last  = $urandom_range(0, first - 1);
            end
            default: begin
                first = $urandom_range(0, 255);
                last  = $urandom_range(0, 255);
            end
        endcase
        add_query(first[POS_W-1:0], last[POS_W-1:0]);
    endtask

    // Driver: presents queued operations in bursts separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                owed_sums.push_back(apply_op(queued_ops.pop_front()));
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                end
            end
            if (s_tvalid && !s_tready) begin
                // Hold the current transfer until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (queued_ops.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {queued_ops[0].range_end, queued_ops[0].range_start,
                             queued_ops[0].value, queued_ops[0].index};
                s_tuser  <= queued_ops[0].kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: a mode picked for a random stretch sets how often it is ready.
    always @(posedge aclk) begin
        if (ready_cycles <= 0) begin
            ready_mode   = $urandom_range(0, 3);
            ready_cycles = $urandom_range(50, 300);
        end
        ready_cycles--;
        m_tready <= (ready_mode == 3) ? 1'b1 : ($urandom_range(0, 3) <= ready_mode);
    end

    // Monitor: every result transfer is compared with the oldest owed sum.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_sums.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                fail_count++;
            end else if (m_tdata !== {4'b0000, owed_sums[0]}) begin
                $display("%0t: range_sum mismatch, expected %h, actual %h",
                         $time, {4'b0000, owed_sums[0]}, m_tdata);
                fail_count++;
                void'(owed_sums.pop_front());
            end else begin
                void'(owed_sums.pop_front());
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        for (int i = 0; i < ELEMENT_COUNT; i++) begin
            element_vals[i] = '0;
        end

        // Directed part: cleared tree, extreme positions and values, range edge cases.
        add_query(8'd0, 8'd255);
        add_write(8'd0, 32'h7fff_ffff);
        add_write(8'd255, 32'h8000_0000);
        add_write(8'd128, 32'hffff_ffff);
        add_write(8'd127, 32'h0000_0001);
        add_query(8'd0, 8'd255);
        add_query(8'd0, 8'd0);
        add_query(8'd255, 8'd255);
        add_query(8'd127, 8'd128);
        add_query(8'd200, 8'd10);
        add_query(8'd128, 8'd127);
        add_query(8'd255, 8'd0);
        add_query(8'd0, 8'd127);
        add_query(8'd128, 8'd255);
        add_write(8'd0, 32'h0000_0000);
        add_write(8'd64, 32'h8000_0000);
        add_write(8'd191, 32'h7fff_ffff);
        add_query(8'd1, 8'd254);
        add_query(8'd64, 8'd191);
        add_write(8'd64, 32'h5a5a_a5a5);
        add_query(8'd0, 8'd255);

        // Build the whole array by a run of writes, then a random mix.
        for (int i = 0; i < ELEMENT_COUNT; i++) begin
            add_write(i[POS_W-1:0], pick_value());
        end
        for (int i = 0; i < 1550; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                add_write(($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom), pick_value());
            end else begin
                add_random_query();
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_ops.size() > 0 || owed_sums.size() > 0 || s_tvalid) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        if (fail_count == 0 && owed_sums.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
